// ===== rtl/frc_pkg.sv =====
package frc_pkg;

  localparam int DATA_WIDTH_DEF = 32;

  typedef struct packed {
    logic busy;
    logic done;
  } frc_stat_t;

endpackage

// ===== rtl/frc_if.sv =====
interface frc_in_if #(
  parameter int W = frc_pkg::DATA_WIDTH_DEF
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] numerator;
  logic signed [W-1:0] denominator;

  modport source (output valid, output numerator, output denominator, input ready);
  modport sink (input valid, input numerator, input denominator, output ready);
  modport mon (input valid, input numerator, input denominator, input ready);
endinterface

interface frc_out_if #(
  parameter int W = frc_pkg::DATA_WIDTH_DEF
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] reduced_numerator;
  logic        [W-2:0] reduced_denominator;
  logic                is_whole;
  logic                divide_by_zero;

  modport source (output valid, output reduced_numerator, output reduced_denominator,
                  output is_whole, output divide_by_zero, input ready);
  modport sink (input valid, input reduced_numerator, input reduced_denominator,
                input is_whole, input divide_by_zero, output ready);
  modport mon (input valid, input reduced_numerator, input reduced_denominator,
               input is_whole, input divide_by_zero, input ready);
endinterface

// ===== rtl/fraction_reducer_top.sv =====
// sequence: a zero or out-of-range input goes from input accept straight to the result state,
//   else binary gcd steps, then shifts that restore the common power of two, then
//   restoring division steps for numerator and denominator on the shared subtractor
// throughput: one item at a time, the next item is taken in the cycle the result shows
//   once the result register is free
// reset: synchronous active-low rst_n clears the sequencer and the output valid
module fraction_reducer_top #(
  parameter int DATA_WIDTH = frc_pkg::DATA_WIDTH_DEF
) (
  input logic   clk,
  input logic   rst_n,
  frc_in_if.sink  in_ch,
  frc_out_if.source out_ch
);
  import frc_pkg::*;

  frc_stat_t stat;
  logic      start, out_free;
  logic signed [DATA_WIDTH-1:0] res_num;
  logic        [DATA_WIDTH-2:0] res_den;
  logic                         res_whole, res_dz;

  logic                         out_valid_r;
  logic signed [DATA_WIDTH-1:0] out_num_r;
  logic        [DATA_WIDTH-2:0] out_den_r;
  logic                         out_whole_r, out_dz_r;

  assign out_free    = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !stat.busy && out_free;
  assign start       = in_ch.valid && in_ch.ready;

  frc_core #(.W(DATA_WIDTH)) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .numerator   (in_ch.numerator),
    .denominator (in_ch.denominator),
    .out_free    (out_free),
    .stat        (stat),
    .res_num     (res_num),
    .res_den     (res_den),
    .res_whole   (res_whole),
    .res_dz      (res_dz)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (stat.done) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.done) begin
      out_num_r   <= res_num;
      out_den_r   <= res_den;
      out_whole_r <= res_whole;
      out_dz_r    <= res_dz;
    end
  end

  assign out_ch.valid               = out_valid_r;
  assign out_ch.reduced_numerator   = out_num_r;
  assign out_ch.reduced_denominator = out_den_r;
  assign out_ch.is_whole            = out_whole_r;
  assign out_ch.divide_by_zero      = out_dz_r;

endmodule

// ===== rtl/frc_core.sv =====
module frc_core #(
  parameter int W = frc_pkg::DATA_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic signed [W-1:0]  numerator,
  input  logic signed [W-1:0]  denominator,
  input  logic                 out_free,
  output frc_pkg::frc_stat_t   stat,
  output logic signed [W-1:0]  res_num,
  output logic        [W-2:0]  res_den,
  output logic                 res_whole,
  output logic                 res_dz
);
  import frc_pkg::*;

  localparam int CW = $clog2(W + 1);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_GCD  = 6'b000010,
    S_SHL  = 6'b000100,
    S_DIVN = 6'b001000,
    S_DIVD = 6'b010000,
    S_FIN  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic [W-1:0]  a_r, a_nxt, b_r, b_nxt, rem_r, rem_nxt, q_r, q_nxt;
  logic [W-1:0]  qn_r, qn_nxt, dmag_r, dmag_nxt;
  logic [CW-1:0] k_r, k_nxt, cnt_r, cnt_nxt;
  logic          neg_r, neg_nxt;
  logic signed [W-1:0] res_num_r, res_num_nxt;
  logic [W-2:0]  res_den_r, res_den_nxt;
  logic          res_whole_r, res_whole_nxt, res_dz_r, res_dz_nxt;

  logic [W-1:0]  n_u, d_u, nmag, dmag, min_val, q_new;
  logic [W:0]    sub_a, sub_b, diff, t;
  logic          borrow, eq;

  assign n_u     = numerator;
  assign d_u     = denominator;
  assign nmag    = n_u[W-1] ? (~n_u + 1'b1) : n_u;
  assign dmag    = d_u[W-1] ? (~d_u + 1'b1) : d_u;
  assign min_val = {1'b1, {(W-1){1'b0}}};

  // one shared subtractor for gcd steps and both divisions
  assign t      = {rem_r, q_r[W-1]};
  assign sub_a  = (state_r == S_GCD) ? {1'b0, a_r} : t;
  assign sub_b  = (state_r == S_GCD) ? {1'b0, b_r} : {1'b0, a_r};
  assign diff   = sub_a - sub_b;
  assign borrow = diff[W];
  assign eq     = (diff == '0);
  assign q_new  = {q_r[W-2:0], ~borrow};

  always_comb begin
    state_nxt     = state_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    rem_nxt       = rem_r;
    q_nxt         = q_r;
    qn_nxt        = qn_r;
    dmag_nxt      = dmag_r;
    k_nxt         = k_r;
    cnt_nxt       = cnt_r;
    neg_nxt       = neg_r;
    res_num_nxt   = res_num_r;
    res_den_nxt   = res_den_r;
    res_whole_nxt = res_whole_r;
    res_dz_nxt    = res_dz_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          neg_nxt       = n_u[W-1] ^ d_u[W-1];
          a_nxt         = nmag;
          b_nxt         = dmag;
          q_nxt         = nmag;
          dmag_nxt      = dmag;
          k_nxt         = '0;
          cnt_nxt       = '0;
          rem_nxt       = '0;
          res_num_nxt   = '0;
          res_den_nxt   = '0;
          res_whole_nxt = 1'b0;
          res_dz_nxt    = 1'b0;
          if (d_u == '0) begin
            res_dz_nxt = 1'b1;
            state_nxt  = S_FIN;
          end else if (n_u == min_val || d_u == min_val) begin
            state_nxt = S_FIN;
          end else if (n_u == '0) begin
            res_den_nxt   = {{(W-2){1'b0}}, 1'b1};
            res_whole_nxt = 1'b1;
            state_nxt     = S_FIN;
          end else begin
            state_nxt = S_GCD;
          end
        end
      end
      S_GCD: begin
        if (eq) begin
          state_nxt = S_SHL;
        end else if (!a_r[0] && !b_r[0]) begin
          a_nxt = a_r >> 1;
          b_nxt = b_r >> 1;
          k_nxt = k_r + 1'b1;
        end else if (!a_r[0]) begin
          a_nxt = a_r >> 1;
        end else if (!b_r[0]) begin
          b_nxt = b_r >> 1;
        end else if (borrow) begin
          a_nxt = b_r;
          b_nxt = a_r;
        end else begin
          a_nxt = diff[W-1:0] >> 1;
        end
      end
      S_SHL: begin
        if (k_r == '0) begin
          rem_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = S_DIVN;
        end else begin
          a_nxt = a_r << 1;
          k_nxt = k_r - 1'b1;
        end
      end
      S_DIVN, S_DIVD: begin
        rem_nxt = borrow ? t[W-1:0] : diff[W-1:0];
        q_nxt   = q_new;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CW'(W - 1)) begin
          if (state_r == S_DIVN) begin
            qn_nxt    = q_new;
            q_nxt     = dmag_r;
            rem_nxt   = '0;
            cnt_nxt   = '0;
            state_nxt = S_DIVD;
          end else begin
            res_num_nxt   = neg_r ? (~qn_r + 1'b1) : qn_r;
            res_den_nxt   = q_new[W-2:0];
            res_whole_nxt = (q_new == {{(W-1){1'b0}}, 1'b1});
            state_nxt     = S_FIN;
          end
        end
      end
      S_FIN: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r         <= a_nxt;
    b_r         <= b_nxt;
    rem_r       <= rem_nxt;
    q_r         <= q_nxt;
    qn_r        <= qn_nxt;
    dmag_r      <= dmag_nxt;
    k_r         <= k_nxt;
    cnt_r       <= cnt_nxt;
    neg_r       <= neg_nxt;
    res_num_r   <= res_num_nxt;
    res_den_r   <= res_den_nxt;
    res_whole_r <= res_whole_nxt;
    res_dz_r    <= res_dz_nxt;
  end

  assign stat.busy = (state_r != S_IDLE);
  assign stat.done = (state_r == S_FIN) && out_free;
  assign res_num   = res_num_r;
  assign res_den   = res_den_r;
  assign res_whole = res_whole_r;
  assign res_dz    = res_dz_r;

endmodule

// ===== rtl/frc_checker.sv =====
module frc_checker #(
  parameter int W = frc_pkg::DATA_WIDTH_DEF
) (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic signed [W-1:0] out_reduced_numerator,
  input logic        [W-2:0] out_reduced_denominator,
  input logic                out_is_whole,
  input logic                out_divide_by_zero
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_reduced_numerator))
    else $error("result item dropped or changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in work");

  a_ready_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid || out_ready)
    else $error("input ready while the result register is full");

  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_divide_by_zero |->
      out_reduced_denominator == '0 && out_reduced_numerator == '0 && !out_is_whole)
    else $error("divide by zero result not cleared");

  a_whole_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_divide_by_zero |->
      out_is_whole == (out_reduced_denominator == (W-1)'(1)))
    else $error("whole flag disagrees with denominator");

endmodule

bind fraction_reducer_top frc_checker #(.W(DATA_WIDTH)) u_frc_checker (
  .clk                     (clk),
  .rst_n                   (rst_n),
  .in_valid                (in_ch.valid),
  .in_ready                (in_ch.ready),
  .out_valid               (out_ch.valid),
  .out_ready               (out_ch.ready),
  .out_reduced_numerator   (out_ch.reduced_numerator),
  .out_reduced_denominator (out_ch.reduced_denominator),
  .out_is_whole            (out_ch.is_whole),
  .out_divide_by_zero      (out_ch.divide_by_zero)
);
